FILE: rtl/dqp_pkg.sv
// Shared types and constants for the DNS query question parser.
// Holds the parse phase and status codes, the result structs and the label
// character check. No dependencies.
`timescale 1ns / 1ps

package dqp_pkg;

  localparam int unsigned MaxPacketBytesDefault = 1024;

  localparam int unsigned HeaderBytes   = 12;
  // The header plus the shortest question: one label byte, its length, the
  // zero byte and four bytes of type and class.
  localparam int unsigned MinQueryBytes = 19;
  localparam int unsigned MaxNameCount  = 255;
  localparam int unsigned TailBytes     = 4;

  localparam logic [15:0] QrMask      = 16'h8000;
  localparam logic [7:0]  CharDot     = 8'h2e;
  localparam logic [7:0]  CaseBit     = 8'h20;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_LEN    = 3'd1,
    PH_LABEL  = 3'd2,
    PH_TAIL   = 3'd3,
    PH_DONE   = 3'd4,
    PH_STOP   = 3'd5
  } phase_e;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_SHORT     = 4'd1,
    ST_RESPONSE  = 4'd2,
    ST_QDCOUNT   = 4'd3,
    ST_ANCOUNT   = 4'd4,
    ST_QSHORT    = 4'd5,
    ST_EMPTY     = 4'd6,
    ST_LONG      = 4'd7,
    ST_TRUNC     = 4'd8,
    ST_CHAR      = 4'd9,
    ST_TYPECLASS = 4'd10
  } status_e;

  typedef struct packed {
    status_e     status;
    logic [15:0] query_id;
    logic [15:0] qtype;
    logic [15:0] qclass;
    logic [7:0]  name_length;
  } verdict_t;

  // Results caused by one input beat: at most one name character and one
  // verdict, the character always first.
  typedef struct packed {
    logic     char_valid;
    logic [7:0] char_data;
    logic     verd_valid;
    verdict_t verd;
  } step_res_t;

  function automatic logic char_ok(input logic [7:0] b);
    logic ok;
    ok = 1'b0;
    if (b >= 8'h30 && b <= 8'h39) ok = 1'b1;
    if (b >= 8'h61 && b <= 8'h7a) ok = 1'b1;
    if (b >= 8'h41 && b <= 8'h5a) ok = 1'b1;
    if (b == 8'h5f || b == 8'h2d) ok = 1'b1;
    return ok;
  endfunction

endpackage

FILE: rtl/dqp_parse_core.sv
// Per-byte parse state of the DNS query question parser.
// Updates header, label and tail state on each accepted byte and forms the
// results that the byte causes. Depends on dqp_pkg.
`timescale 1ns / 1ps

module dqp_parse_core import dqp_pkg::*; #(
  parameter int unsigned MAX_PACKET_BYTES = MaxPacketBytesDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output step_res_t  res_o
);

  localparam int unsigned PosW = $clog2(MAX_PACKET_BYTES + 1);

  logic [PosW-1:0] pos_q, pos_d;
  phase_e          phase_q, phase_d;
  logic [15:0]     id_q, id_d;
  logic [15:0]     hw_q, hw_d;
  logic [7:0]      lrem_q, lrem_d;
  logic [8:0]      ncount_q, ncount_d;
  status_e         err_q, err_d;
  logic            bad_q, bad_d;
  logic            dot_q, dot_d;
  logic [31:0]     tc_q, tc_d;

  logic [8:0]      nsum;
  logic            named;

  always_comb begin
    pos_d    = pos_q;
    phase_d  = phase_q;
    id_d     = id_q;
    hw_d     = hw_q;
    lrem_d   = lrem_q;
    ncount_d = ncount_q;
    err_d    = err_q;
    bad_d    = bad_q;
    dot_d    = dot_q;
    tc_d     = tc_q;
    res_o    = '0;
    nsum     = ncount_q + {1'b0, byte_i} + 9'd1;
    named    = 1'b0;

    if (fire_i) begin
      if (pos_q < PosW'(MAX_PACKET_BYTES)) begin
        pos_d = pos_q + PosW'(1);
        case (phase_q)
          PH_HEADER: begin
            hw_d = {hw_q[7:0], byte_i};
            if (pos_q == PosW'(0)) id_d = {byte_i, 8'h00};
            if (pos_q == PosW'(1)) id_d = {id_q[15:8], byte_i};
            if (err_q == ST_OK) begin
              if (pos_q == PosW'(3) && (hw_d & QrMask) != 16'h0000) err_d = ST_RESPONSE;
              if (pos_q == PosW'(5) && hw_d != 16'h0001) err_d = ST_QDCOUNT;
              if (pos_q == PosW'(7) && hw_d != 16'h0000) err_d = ST_ANCOUNT;
            end
            if (pos_q == PosW'(HeaderBytes - 1)) begin
              phase_d = (err_d != ST_OK) ? PH_STOP : PH_LEN;
            end
          end
          PH_LEN: begin
            if (byte_i == 8'h00) begin
              if (ncount_q == 9'd0) begin
                if (err_q == ST_OK) err_d = ST_EMPTY;
                phase_d = PH_STOP;
              end else begin
                lrem_d  = 8'(TailBytes);
                phase_d = PH_TAIL;
              end
            end else begin
              ncount_d = nsum;
              if (nsum > 9'(MaxNameCount)) begin
                if (err_q == ST_OK) err_d = ST_LONG;
                phase_d = PH_STOP;
              end else begin
                // The dot that closes the previous label goes out only once
                // another label follows it.
                res_o.char_valid = dot_q;
                res_o.char_data  = CharDot;
                lrem_d  = byte_i;
                bad_d   = 1'b0;
                phase_d = PH_LABEL;
              end
            end
          end
          PH_LABEL: begin
            bad_d = bad_q | ~char_ok(byte_i);
            res_o.char_valid = 1'b1;
            res_o.char_data  = (byte_i >= 8'h41 && byte_i <= 8'h5a) ? (byte_i | CaseBit)
                                                                    : byte_i;
            lrem_d = lrem_q - 8'd1;
            if (lrem_d == 8'd0) begin
              if (bad_d) begin
                if (err_q == ST_OK) err_d = ST_CHAR;
                phase_d = PH_STOP;
              end else begin
                dot_d   = 1'b1;
                phase_d = PH_LEN;
              end
            end
          end
          PH_TAIL: begin
            tc_d   = {tc_q[23:0], byte_i};
            lrem_d = lrem_q - 8'd1;
            if (lrem_d == 8'd0) phase_d = PH_DONE;
          end
          default: begin
          end
        endcase
      end

      if (last_i) begin
        res_o.verd_valid        = 1'b1;
        res_o.verd.query_id     = id_d;
        res_o.verd.qtype        = tc_d[31:16];
        res_o.verd.qclass       = tc_d[15:0];
        named = (phase_d == PH_TAIL) || (phase_d == PH_DONE);
        if (named && ncount_d != 9'd0) begin
          res_o.verd.name_length = 8'(ncount_d - 9'd1);
        end
        if (pos_d < PosW'(HeaderBytes)) begin
          res_o.verd.status = ST_SHORT;
        end else if (err_d == ST_RESPONSE || err_d == ST_QDCOUNT || err_d == ST_ANCOUNT) begin
          res_o.verd.status = err_d;
        end else if (pos_d < PosW'(MinQueryBytes)) begin
          res_o.verd.status = ST_QSHORT;
        end else if (err_d != ST_OK) begin
          res_o.verd.status = err_d;
        end else if (phase_d == PH_LEN || phase_d == PH_LABEL) begin
          res_o.verd.status = ST_TRUNC;
        end else if (phase_d == PH_TAIL) begin
          res_o.verd.status = ST_QSHORT;
        end else if (tc_d[31:16] != 16'h0001 || tc_d[15:0] != 16'h0001) begin
          res_o.verd.status = ST_TYPECLASS;
        end else begin
          res_o.verd.status = ST_OK;
        end
        if (res_o.verd.status != ST_OK && res_o.verd.status != ST_TYPECLASS) begin
          res_o.verd.qtype  = 16'h0000;
          res_o.verd.qclass = 16'h0000;
        end

        // The packet is over: start the next one from the reset state.
        pos_d    = '0;
        phase_d  = PH_HEADER;
        id_d     = '0;
        hw_d     = '0;
        lrem_d   = '0;
        ncount_d = '0;
        err_d    = ST_OK;
        bad_d    = 1'b0;
        dot_d    = 1'b0;
        tc_d     = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      phase_q  <= PH_HEADER;
      id_q     <= '0;
      hw_q     <= '0;
      lrem_q   <= '0;
      ncount_q <= '0;
      err_q    <= ST_OK;
      bad_q    <= 1'b0;
      dot_q    <= 1'b0;
      tc_q     <= '0;
    end else begin
      pos_q    <= pos_d;
      phase_q  <= phase_d;
      id_q     <= id_d;
      hw_q     <= hw_d;
      lrem_q   <= lrem_d;
      ncount_q <= ncount_d;
      err_q    <= err_d;
      bad_q    <= bad_d;
      dot_q    <= dot_d;
      tc_q     <= tc_d;
    end
  end

endmodule

FILE: rtl/dns_query_question_parser.sv
// Top level of the DNS query question parser: stream ports and result buffer.
// Instantiates dqp_parse_core; depends on dqp_pkg.
`timescale 1ns / 1ps

// Usage
// The slave stream carries a DNS request one byte per beat; tlast marks the
// final byte of the packet. The master stream returns the question name as
// lower-case dotted text, one character per beat with tuser low, followed
// by one verdict beat with tuser and tlast high that carries the status,
// id, type, class and name length.
// The results of a byte are offered in the cycle after the byte is taken.
// The parse state is updated in the cycle a byte is accepted, so a byte can
// be taken every cycle while the receiver takes each result. A byte causes
// at most a character and, on the last byte, a verdict; when both are
// pending the slave side waits while the character beat goes out, so the
// final byte of a packet can hold off the next byte.
// While the receiver stalls, pending results hold and the slave side is
// held off once the buffer cannot drain. Reset clears the parse state and
// drops any pending results; the next byte starts a new packet. Bytes past
// MAX_PACKET_BYTES are ignored, but their tlast still closes the packet.
module dns_query_question_parser import dqp_pkg::*; #(
  parameter int unsigned MAX_PACKET_BYTES = MaxPacketBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,   // last_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] name_char, [11:8] status, [27:12] query_id, [43:28] question type,
  // [59:44] question class, [67:60] name_length, [71:68] zero
  output logic [71:0] m_axis_tdata_o,
  output logic        m_axis_tuser_o,   // kind
  output logic        m_axis_tlast_o    // final_res
);

  step_res_t  step_res;
  logic       in_fire;
  logic       out_fire;

  // Result buffer: a pending character beat and a pending verdict beat.
  logic       char_v_q, char_v_d;
  logic [7:0] char_q;
  logic       verd_v_q, verd_v_d;
  verdict_t   verd_q;

  dqp_parse_core #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (in_fire),
    .byte_i (s_axis_tdata_i),
    .last_i (s_axis_tlast_i),
    .res_o  (step_res)
  );

  assign out_fire = m_axis_tvalid_o & m_axis_tready_i;

  // A new byte may enter once the buffer is empty or its only beat leaves
  // in this cycle.
  assign s_axis_tready_o = ~(char_v_q | verd_v_q) | (out_fire & ~(char_v_q & verd_v_q));
  assign in_fire         = s_axis_tvalid_i & s_axis_tready_o;

  always_comb begin
    char_v_d = char_v_q;
    verd_v_d = verd_v_q;
    if (in_fire) begin
      char_v_d = step_res.char_valid;
      verd_v_d = step_res.verd_valid;
    end else if (out_fire) begin
      // The character always leaves ahead of the verdict.
      if (char_v_q) begin
        char_v_d = 1'b0;
      end else begin
        verd_v_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_v_q <= 1'b0;
      verd_v_q <= 1'b0;
    end else begin
      char_v_q <= char_v_d;
      verd_v_q <= verd_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      char_q <= step_res.char_data;
      verd_q <= step_res.verd;
    end
  end

  assign m_axis_tvalid_o = char_v_q | verd_v_q;
  assign m_axis_tuser_o  = ~char_v_q;
  assign m_axis_tlast_o  = ~char_v_q;
  always_comb begin
    if (char_v_q) begin
      m_axis_tdata_o = {64'h0, char_q};
    end else begin
      m_axis_tdata_o = {4'h0, verd_q.name_length, verd_q.qclass, verd_q.qtype,
                        verd_q.query_id, verd_q.status, 8'h00};
    end
  end

  // Every packet end leaves exactly one verdict behind it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && s_axis_tlast_i |=> verd_v_q)
    else $error("packet end without a verdict");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !s_axis_tlast_i |=> !verd_v_q)
    else $error("verdict without a packet end");

  // With two beats pending the buffer cannot take another byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    char_v_q && verd_v_q |-> !s_axis_tready_o)
    else $error("byte taken while the result buffer is full");

  // A verdict never overtakes the character it follows.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    char_v_q && verd_v_q && out_fire |=> verd_v_q && !char_v_q)
    else $error("result beats out of order");

endmodule
